FILE: hw/rtl/h10p_pkg.sv
// ----------------------------------------------------------------------------
// h10p_pkg
// Shared types, constants and lookup functions for the HTTP/1.0 parser.
// ----------------------------------------------------------------------------
package h10p_pkg;

  localparam int unsigned LenBitsDefault = 31;
  localparam int unsigned NumNames       = 16;
  localparam int unsigned NameLitW       = 17 * 8;

  // Parse phases, one-hot
  typedef enum logic [13:0] {
    PH_FIRST   = 14'b00000000000001,
    PH_URI     = 14'b00000000000010,
    PH_RVER    = 14'b00000000000100,
    PH_LINE_LF = 14'b00000000001000,
    PH_STATUS  = 14'b00000000010000,
    PH_REASON  = 14'b00000000100000,
    PH_HSTART  = 14'b00000001000000,
    PH_HNAME   = 14'b00000010000000,
    PH_HSP     = 14'b00000100000000,
    PH_HVAL    = 14'b00001000000000,
    PH_CLVAL   = 14'b00010000000000,
    PH_HLF     = 14'b00100000000000,
    PH_ELF     = 14'b01000000000000,
    PH_BODY    = 14'b10000000000000
  } phase_e;

  typedef enum logic [3:0] {
    ROLE_DELIM   = 4'd0,
    ROLE_METHOD  = 4'd1,
    ROLE_URI     = 4'd2,
    ROLE_VERSION = 4'd3,
    ROLE_STATUS  = 4'd4,
    ROLE_REASON  = 4'd5,
    ROLE_HNAME   = 4'd6,
    ROLE_HVALUE  = 4'd7,
    ROLE_BODY    = 4'd8
  } role_e;

  typedef enum logic [1:0] {
    HK_EXT   = 2'd0,
    HK_DATE  = 2'd1,
    HK_CLEN  = 2'd2,
    HK_OTHER = 2'd3
  } hkind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_BYTE    = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_STATUS  = 3'd3,
    ERR_LENGTH  = 3'd4
  } err_e;

  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCl = 8'h3A;

  localparam logic [63:0] HttpWord = "HTTP/1.0";
  localparam logic [9:0]  StatusMin = 10'd100;
  localparam logic [9:0]  StatusMax = 10'd999;
  localparam logic [9:0]  StatusSat = 10'd1000;
  localparam logic [4:0]  PosMax    = 5'd31;

  // Known header names, right-justified string literals
  localparam logic [NameLitW-1:0] Names [NumNames] = '{
    "Date", "Content-Length", "Pragma", "Authorization", "From",
    "If-Modified-Since", "Referer", "User-Agent", "Location", "Server",
    "WWW-Authenticate", "Allow", "Content-Encoding", "Content-Type",
    "Expires", "Last-Modified"
  };
  localparam logic [4:0] NameLen [NumNames] = '{
    5'd4, 5'd14, 5'd6, 5'd13, 5'd4, 5'd17, 5'd7, 5'd10, 5'd8, 5'd6,
    5'd16, 5'd5, 5'd16, 5'd12, 5'd7, 5'd13
  };

  // Per-message control state (fixed widths)
  typedef struct packed {
    phase_e          phase;
    logic [4:0]      pos;
    logic            prefix_ok;
    logic            version_ok;
    logic            response;
    logic [NumNames-1:0] cand;
    logic [9:0]      status;
    logic            len_seen;
    logic            err;
    err_e            err_code;
  } ctl_t;

  function automatic logic is_tok(input logic [7:0] c);
    return (c > 8'h20) && (c < 8'h7F) && (c != ChCl);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Byte of "HTTP/1.0" at position p (p below 8)
  function automatic logic [7:0] http_char(input logic [2:0] p);
    return HttpWord[(3'd7 - p) * 8 +: 8];
  endfunction

endpackage

FILE: hw/rtl/h10p_name_match.sv
// ----------------------------------------------------------------------------
// h10p_name_match
// Narrows the set of known header names that still match the name so far.
// ----------------------------------------------------------------------------
module h10p_name_match (
  input  logic [h10p_pkg::NumNames-1:0] cand_i,
  input  logic [4:0]                    pos_i,
  input  logic [7:0]                    byte_i,
  output logic [h10p_pkg::NumNames-1:0] cand_tok_o,  // after one more name byte
  output logic [h10p_pkg::NumNames-1:0] cand_end_o   // after the name ends here
);
  import h10p_pkg::*;

  // One comparator per known name
  always_comb begin
    for (int i = 0; i < NumNames; i++) begin
      cand_tok_o[i] = cand_i[i] && (pos_i < NameLen[i]) &&
                      (byte_i == Names[i][(NameLen[i] - 5'd1 - pos_i) * 8 +: 8]);
      cand_end_o[i] = cand_i[i] && (pos_i == NameLen[i]);
    end
  end

endmodule

FILE: hw/rtl/h10p_step.sv
// ----------------------------------------------------------------------------
// h10p_step
// Next-state and per-byte result logic of the parser.
// ----------------------------------------------------------------------------
module h10p_step #(
  parameter int unsigned LENGTH_BITS = h10p_pkg::LenBitsDefault
) (
  input  h10p_pkg::ctl_t         ctl_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  input  logic [LENGTH_BITS-1:0] rem_i,
  input  logic [7:0]             byte_i,
  output h10p_pkg::ctl_t         ctl_o,
  output logic [LENGTH_BITS-1:0] len_o,
  output logic [LENGTH_BITS-1:0] rem_o,
  output h10p_pkg::role_e        role_o,
  output h10p_pkg::hkind_e       kind_o,
  output logic                   done_o,
  output logic [LENGTH_BITS-1:0] len_rpt_o   // length as reported with this byte
);
  import h10p_pkg::*;

  localparam int unsigned LenW = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LenOne = LENGTH_BITS'(1);

  logic [NumNames-1:0] m_cand, cand_tok, cand_end, cand_fin;
  logic [4:0]          m_pos, pos_inc;
  logic                tok, dig;
  logic [3:0]          dval;
  logic [13:0]         st_prod;
  logic [LenW-1:0]     len_prod;
  logic                tail;
  ctl_t                n;
  role_e               role;

  assign tok     = is_tok(byte_i);
  assign dig     = is_digit(byte_i);
  assign dval    = byte_i[3:0];
  assign pos_inc = (ctl_i.pos < PosMax) ? ctl_i.pos + 5'd1 : ctl_i.pos;
  assign st_prod = {4'd0, ctl_i.status} * 14'd10 + {10'd0, dval};
  assign len_prod = ({4'd0, len_i} << 3) + ({4'd0, len_i} << 1) +
                    {{(LenW-4){1'b0}}, dval};

  // Header start restarts the candidate set at position zero
  assign m_cand = (ctl_i.phase == PH_HSTART) ? '1 : ctl_i.cand;
  assign m_pos  = (ctl_i.phase == PH_HSTART) ? 5'd0 : ctl_i.pos;

  h10p_name_match u_match (
    .cand_i     (m_cand),
    .pos_i      (m_pos),
    .byte_i     (byte_i),
    .cand_tok_o (cand_tok),
    .cand_end_o (cand_end)
  );

  // Main per-byte decode
  always_comb begin
    n     = ctl_i;
    len_o = len_i;
    rem_o = rem_i;
    role  = ROLE_DELIM;
    done_o = 1'b0;
    if (!ctl_i.err) begin
      case (ctl_i.phase)
        PH_FIRST, PH_RVER: begin
          if (tok) begin
            if (ctl_i.pos < 5'd4 && byte_i != http_char(ctl_i.pos[2:0])) n.prefix_ok = 1'b0;
            if (ctl_i.pos >= 5'd8 || byte_i != http_char(ctl_i.pos[2:0]))
              n.version_ok = 1'b0;
            n.pos = pos_inc;
            if (ctl_i.phase == PH_RVER) role = ROLE_VERSION;
            else role = n.prefix_ok ? ROLE_VERSION : ROLE_METHOD;
          end else if (ctl_i.phase == PH_RVER) begin
            if (!(ctl_i.version_ok && ctl_i.pos == 5'd8)) begin
              n.err = 1'b1; n.err_code = ERR_VERSION;
            end else if (byte_i != ChCr) begin
              n.err = 1'b1; n.err_code = ERR_BYTE;
            end else n.phase = PH_LINE_LF;
          end else if (ctl_i.prefix_ok && ctl_i.pos >= 5'd4) begin
            n.response = 1'b1;
            if (!(ctl_i.version_ok && ctl_i.pos == 5'd8)) begin
              n.err = 1'b1; n.err_code = ERR_VERSION;
            end else if (byte_i != ChSp) begin
              n.err = 1'b1; n.err_code = ERR_BYTE;
            end else begin
              n.phase = PH_STATUS; n.pos = 5'd0; n.status = 10'd0;
            end
          end else if (byte_i != ChSp) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else n.phase = PH_URI;
        end
        PH_URI: begin
          if (tok || byte_i == ChCl) role = ROLE_URI;
          else if (byte_i != ChSp) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else begin
            n.phase = PH_RVER; n.pos = 5'd0; n.prefix_ok = 1'b1; n.version_ok = 1'b1;
          end
        end
        PH_LINE_LF, PH_HLF: begin
          if (byte_i != ChLf) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else n.phase = PH_HSTART;
        end
        PH_STATUS: begin
          if (tok) begin
            if (!dig) begin
              n.err = 1'b1; n.err_code = ERR_STATUS;
            end else begin
              n.status = (st_prod > 14'd999) ? StatusSat : st_prod[9:0];
              n.pos = pos_inc;
              role = ROLE_STATUS;
            end
          end else if (ctl_i.pos == 5'd0 || ctl_i.status < StatusMin ||
                       ctl_i.status > StatusMax) begin
            n.err = 1'b1; n.err_code = ERR_STATUS;
          end else if (byte_i != ChSp) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else n.phase = PH_REASON;
        end
        PH_REASON, PH_HVAL: begin
          if (tok || byte_i == ChSp || byte_i == ChCl)
            role = (ctl_i.phase == PH_REASON) ? ROLE_REASON : ROLE_HVALUE;
          else if (byte_i != ChCr) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else n.phase = (ctl_i.phase == PH_REASON) ? PH_LINE_LF : PH_HLF;
        end
        PH_HSTART, PH_HNAME: begin
          if (ctl_i.phase == PH_HSTART && byte_i == ChCr) n.phase = PH_ELF;
          else begin
            n.phase = PH_HNAME;
            if (tok) begin
              n.cand = cand_tok;
              n.pos  = (m_pos < PosMax) ? m_pos + 5'd1 : m_pos;
              role   = ROLE_HNAME;
            end else begin
              n.cand = cand_end;
              n.pos  = m_pos;
              if (byte_i != ChCl) begin
                n.err = 1'b1; n.err_code = ERR_BYTE;
              end else n.phase = PH_HSP;
            end
          end
        end
        PH_HSP: begin
          if (byte_i != ChSp) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else begin
            n.pos = 5'd0;
            if (ctl_i.cand[1]) begin
              n.phase = PH_CLVAL; len_o = '0;
            end else n.phase = PH_HVAL;
          end
        end
        PH_CLVAL: begin
          if (tok) begin
            if (!dig || len_prod[LenW-1:LENGTH_BITS] != '0) begin
              n.err = 1'b1; n.err_code = ERR_LENGTH;
            end else begin
              len_o = len_prod[LENGTH_BITS-1:0];
              n.pos = pos_inc;
              role  = ROLE_HVALUE;
            end
          end else if (ctl_i.pos == 5'd0) begin
            n.err = 1'b1; n.err_code = ERR_LENGTH;
          end else begin
            n.len_seen = 1'b1;
            if (byte_i != ChCr) begin
              n.err = 1'b1; n.err_code = ERR_BYTE;
            end else n.phase = PH_HLF;
          end
        end
        PH_ELF: begin
          if (byte_i != ChLf) begin
            n.err = 1'b1; n.err_code = ERR_BYTE;
          end else if (ctl_i.len_seen && len_i != '0) begin
            n.phase = PH_BODY; rem_o = len_i;
          end else done_o = 1'b1;
        end
        PH_BODY: begin
          role = ROLE_BODY;
          if (rem_i != '0) rem_o = rem_i - LenOne;
          if (rem_o == '0) done_o = 1'b1;
        end
        default: begin
          n.err = 1'b1; n.err_code = ERR_BYTE;
        end
      endcase
    end
  end

  assign cand_fin = n.cand;
  assign tail = (ctl_i.phase == PH_HSP) || (ctl_i.phase == PH_HVAL) ||
                (ctl_i.phase == PH_CLVAL) || (ctl_i.phase == PH_HLF) ||
                (((ctl_i.phase == PH_HSTART) || (ctl_i.phase == PH_HNAME)) &&
                 (n.phase == PH_HSP));

  // Result fields, with error masking
  always_comb begin
    role_o = role;
    kind_o = HK_EXT;
    if (n.err) begin
      role_o = ROLE_DELIM;
    end else if (tail) begin
      if (cand_fin[0])      kind_o = HK_DATE;
      else if (cand_fin[1]) kind_o = HK_CLEN;
      else if (|cand_fin)   kind_o = HK_OTHER;
    end
  end

  assign len_rpt_o = len_o;

  // Completed message returns to the start state
  always_comb begin
    ctl_o = n;
    if (done_o && !n.err) begin
      ctl_o.phase      = PH_FIRST;
      ctl_o.pos        = 5'd0;
      ctl_o.prefix_ok  = 1'b1;
      ctl_o.version_ok = 1'b1;
      ctl_o.response   = 1'b0;
      ctl_o.cand       = '1;
      ctl_o.status     = 10'd0;
      ctl_o.len_seen   = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/http10_message_parser.sv
// ----------------------------------------------------------------------------
// http10_message_parser
// Byte-stream HTTP/1.0 message parser with per-byte role tagging.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and one tagged result comes out per byte, in the
// next cycle, from a single output register; the parse state is updated in
// the same cycle the byte is accepted, so back-to-back bytes run at full rate
// whenever the output side is not stalled. Setting tuser (restart) on a byte
// clears the parse state and any sticky error before that byte is parsed.
// After a byte flags an error, every byte until restart is tagged as a
// delimiter with error set. A completed message (message_done on its last
// byte) leaves the parser ready for the next message at once.
module http10_message_parser #(
  parameter int unsigned LENGTH_BITS = h10p_pkg::LenBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_echo, byte_role, header_kind, is_response, status value,
  // length value, length_present, message_done, error, error_kind
  output logic [((LENGTH_BITS + 31 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import h10p_pkg::*;

  localparam int unsigned OutW   = LENGTH_BITS + 31;
  localparam int unsigned TdataW = ((OutW + 7) / 8) * 8;

  localparam ctl_t CtlReset = '{
    phase: PH_FIRST, pos: 5'd0, prefix_ok: 1'b1, version_ok: 1'b1,
    response: 1'b0, cand: '1, status: 10'd0, len_seen: 1'b0,
    err: 1'b0, err_code: ERR_NONE
  };

  ctl_t                   ctl_q, ctl_d, ctl_in;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_in, rem_q, rem_d, rem_in, len_rpt;
  role_e                  role;
  hkind_e                 kind;
  logic                   done, accept, msg_end;
  logic                   out_valid_q;
  logic [OutW-1:0]        out_q, out_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Restart applies before the byte is parsed
  assign ctl_in = s_axis_tuser ? CtlReset : ctl_q;
  assign len_in = s_axis_tuser ? '0 : len_q;
  assign rem_in = s_axis_tuser ? '0 : rem_q;

  h10p_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .ctl_i     (ctl_in),
    .len_i     (len_in),
    .rem_i     (rem_in),
    .byte_i    (s_axis_tdata),
    .ctl_o     (ctl_d),
    .len_o     (len_d),
    .rem_o     (rem_d),
    .role_o    (role),
    .kind_o    (kind),
    .done_o    (done),
    .len_rpt_o (len_rpt)
  );

  // Last byte of a message: the next state is already cleared, so report
  // the message fields as they stood (the ending bytes never change them)
  assign msg_end = done && !ctl_d.err;

  // Result packing, highest field first
  assign out_d = {ctl_d.err_code, ctl_d.err, msg_end,
                  msg_end ? ctl_in.len_seen : ctl_d.len_seen,
                  len_rpt,
                  msg_end ? ctl_in.status : ctl_d.status,
                  msg_end ? ctl_in.response : ctl_d.response,
                  kind, role, s_axis_tdata};

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CtlReset;
      len_q <= '0;
      rem_q <= '0;
    end else if (accept) begin
      ctl_q <= ctl_d;
      len_q <= msg_end ? '0 : len_d;
      rem_q <= msg_end ? '0 : rem_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'(out_q);

endmodule
